// ===== sv/top4_weight_quantizer_macros.svh =====
// Assertion macros for the top-4 weight quantizer.
`ifndef TOP4_WEIGHT_QUANTIZER_MACROS_SVH
`define TOP4_WEIGHT_QUANTIZER_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define T4Q_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define T4Q_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/t4q_pkg.sv =====
// Package: types, constants and helpers of the top-4 weight quantizer.
`default_nettype none
package t4q_pkg;
  localparam int NumBiomes = 8;
  localparam int NumIn = 8;
  localparam int MaxKeep = 4;
  localparam int FullScale = 255;
  localparam int DivStages = 8;

  typedef logic signed [15:0] weight_t;
  typedef logic [2:0] idx_t;
  typedef logic [14:0] mag_t;
  typedef logic [16:0] sum_t;
  typedef logic [22:0] prod_t;
  typedef logic [7:0] share_t;

  typedef struct packed {
    logic valid;
    logic [MaxKeep-1:0] on;
    idx_t [MaxKeep-1:0] idx;
    mag_t [MaxKeep-1:0] kw;
    logic [2:0] cnt;
  } sel_t;

  // Lane context traveling alongside the dividers.
  typedef struct packed {
    logic valid;
    logic [MaxKeep-1:0] on;
    idx_t [MaxKeep-1:0] idx;
    logic [2:0] cnt;
  } ctx_t;

  // w_a outranks w_b; equal weights go to the lower index.
  function automatic logic beats(input weight_t wa, input idx_t ia,
                                 input weight_t wb, input idx_t ib);
    beats = (wa > wb) || ((wa == wb) && (ia < ib));
  endfunction
endpackage
`default_nettype wire

// ===== sv/top4_weight_quantizer.sv =====
// Top level of the top-4 weight quantizer.
// Usage:
//  - Drive in_weight_0..7 and pulse start; an item is accepted whenever start
//    is high and busy is low. busy is always low: one item every cycle.
//  - Stage 1 ranks the eight weights in one registered compare network and
//    keeps up to four strongest positive ones (ties to lower biome index).
//  - Stage 2 sums the kept weights and forms w*255 in four lanes.
//  - Four divider lanes, 8 pipeline stages each (one quotient bit a stage),
//    give floor(w*255/sum) and the exact remainder.
//  - The merge stage gives the leftover units to the largest remainders.
//  - Items pass sel_r, ctx_r[0], the divider stages and the merge register;
//    throughput one item per cycle, set by the fully pipelined divider lanes.
//  - Results appear for exactly one cycle with out_strobe high; the receiver
//    cannot stall, so nothing is held back.
//  - Reset (rst_n low, synchronous) clears all valid flags; items in flight
//    are dropped.
//  - No positive weight: all result fields are zero.
`default_nettype none
module top4_weight_quantizer (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  logic signed [15:0] in_weight_0,
  input  logic signed [15:0] in_weight_1,
  input  logic signed [15:0] in_weight_2,
  input  logic signed [15:0] in_weight_3,
  input  logic signed [15:0] in_weight_4,
  input  logic signed [15:0] in_weight_5,
  input  logic signed [15:0] in_weight_6,
  input  logic signed [15:0] in_weight_7,
  output logic out_strobe,
  output logic [2:0] out_layer_0,
  output logic [2:0] out_layer_1,
  output logic [2:0] out_layer_2,
  output logic [2:0] out_layer_3,
  output logic [7:0] out_share_0,
  output logic [7:0] out_share_1,
  output logic [7:0] out_share_2,
  output logic [7:0] out_share_3,
  output logic [2:0] out_kept_count
);
`include "top4_weight_quantizer_macros.svh"

  t4q_pkg::weight_t [t4q_pkg::NumIn-1:0] w;
  t4q_pkg::sel_t sel_r;
  t4q_pkg::prod_t [t4q_pkg::MaxKeep-1:0] prod_r, prod_nxt;
  t4q_pkg::sum_t sum_r, sum_nxt;
  t4q_pkg::ctx_t ctx_r [t4q_pkg::DivStages+1];
  t4q_pkg::share_t [t4q_pkg::MaxKeep-1:0] quo;
  t4q_pkg::sum_t [t4q_pkg::MaxKeep-1:0] rem;
  t4q_pkg::idx_t [t4q_pkg::MaxKeep-1:0] layer;
  t4q_pkg::share_t [t4q_pkg::MaxKeep-1:0] share;

  assign busy = 1'b0;
  assign w = {in_weight_7, in_weight_6, in_weight_5, in_weight_4,
              in_weight_3, in_weight_2, in_weight_1, in_weight_0};

  t4q_select u_sel (
    .clk(clk), .rst_n(rst_n), .in_valid(start && !busy), .w(w), .sel_r(sel_r)
  );

  // Sum and scale stage.
  always_comb begin
    sum_nxt = '0;
    for (int k = 0; k < t4q_pkg::MaxKeep; k++) begin
      prod_nxt[k] = '0;
      if (sel_r.on[k]) begin
        sum_nxt = sum_nxt + 17'(sel_r.kw[k]);
        prod_nxt[k] = (23'(sel_r.kw[k]) << 8) - 23'(sel_r.kw[k]);
      end
    end
    // Empty set: divide by 1 to keep lanes quiet; outputs are masked anyway.
    if (sel_r.cnt == 3'd0) sum_nxt = 17'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r[0].valid <= 1'b0;
    end else begin
      ctx_r[0].valid <= sel_r.valid;
    end
    ctx_r[0].on <= sel_r.on;
    ctx_r[0].idx <= sel_r.idx;
    ctx_r[0].cnt <= sel_r.cnt;
    prod_r <= prod_nxt;
    sum_r <= sum_nxt;
  end

  // Context pipe matches the divider depth.
  for (genvar s = 0; s < t4q_pkg::DivStages; s++) begin : g_ctx
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctx_r[s+1].valid <= 1'b0;
      end else begin
        ctx_r[s+1].valid <= ctx_r[s].valid;
      end
      ctx_r[s+1].on <= ctx_r[s].on;
      ctx_r[s+1].idx <= ctx_r[s].idx;
      ctx_r[s+1].cnt <= ctx_r[s].cnt;
    end
  end

  for (genvar k = 0; k < t4q_pkg::MaxKeep; k++) begin : g_lane
    t4q_div_lane u_div (
      .clk(clk), .prod(prod_r[k]), .sum(sum_r), .quo_r(quo[k]), .rem_r(rem[k])
    );
  end

  logic [2:0] cnt;
  t4q_merge u_merge (
    .clk(clk), .rst_n(rst_n),
    .ctx(ctx_r[t4q_pkg::DivStages]),
    .quo(quo), .rem(rem), .out_strobe(out_strobe),
    .layer_r(layer), .share_r(share), .cnt_r(cnt)
  );

  assign out_layer_0 = layer[0];
  assign out_layer_1 = layer[1];
  assign out_layer_2 = layer[2];
  assign out_layer_3 = layer[3];
  assign out_share_0 = share[0];
  assign out_share_1 = share[1];
  assign out_share_2 = share[2];
  assign out_share_3 = share[3];
  assign out_kept_count = cnt;

  `T4Q_ASSERT_IMPL(a_sum_255, out_strobe && cnt != 3'd0,
    9'(share[0]) + 9'(share[1]) + 9'(share[2]) + 9'(share[3]) == 9'd255)
  `T4Q_ASSERT_IMPL(a_empty, out_strobe && cnt == 3'd0,
    share[0] == 8'd0 && layer[0] == 3'd0)
  `T4Q_ASSERT_NEXT(a_sel_cnt, sel_r.valid, ctx_r[0].cnt <= 3'd4)
endmodule
`default_nettype wire

// ===== sv/t4q_select.sv =====
// Ranking stage: picks up to four strongest positive weights.
`default_nettype none
module t4q_select (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  t4q_pkg::weight_t [t4q_pkg::NumIn-1:0] w,
  output t4q_pkg::sel_t sel_r
);
  t4q_pkg::sel_t sel_nxt;
  logic [t4q_pkg::NumIn-1:0] act;
  logic [2:0] rank [t4q_pkg::NumIn];

  always_comb begin
    sel_nxt = '0;
    sel_nxt.valid = in_valid;
    for (int i = 0; i < t4q_pkg::NumIn; i++) begin
      act[i] = (i < t4q_pkg::NumBiomes) && (w[i] > 16'sd0);
      rank[i] = '0;
      for (int j = 0; j < t4q_pkg::NumIn; j++) begin
        if (j != i && act[i] && (j < t4q_pkg::NumBiomes) && (w[j] > 16'sd0) &&
            t4q_pkg::beats(w[j], 3'(j), w[i], 3'(i)))
          rank[i] = rank[i] + 3'd1;
      end
    end
    for (int i = 0; i < t4q_pkg::NumIn; i++) begin
      if (act[i]) begin
        for (int k = 0; k < t4q_pkg::MaxKeep; k++) begin
          if (rank[i] == 3'(k)) begin
            sel_nxt.on[k] = 1'b1;
            sel_nxt.idx[k] = 3'(i);
            sel_nxt.kw[k] = w[i][14:0];
          end
        end
      end
    end
    sel_nxt.cnt = 3'($countones(sel_nxt.on));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r.valid <= 1'b0;
    end else begin
      sel_r.valid <= sel_nxt.valid;
    end
    sel_r.on <= sel_nxt.on;
    sel_r.idx <= sel_nxt.idx;
    sel_r.kw <= sel_nxt.kw;
    sel_r.cnt <= sel_nxt.cnt;
  end
endmodule
`default_nettype wire

// ===== sv/t4q_div_lane.sv =====
// Pipelined restoring divider lane: w*255 / sum, quotient 8 bits, remainder.
`default_nettype none
module t4q_div_lane (
  input  logic clk,
  input  t4q_pkg::prod_t prod,
  input  t4q_pkg::sum_t sum,
  output t4q_pkg::share_t quo_r,
  output t4q_pkg::sum_t rem_r
);
  // Quotient fits 8 bits since w <= sum; 8 stages, one bit each.
  t4q_pkg::prod_t p_r [t4q_pkg::DivStages+1];
  t4q_pkg::sum_t d_r [t4q_pkg::DivStages+1];
  logic [17:0] r_r [t4q_pkg::DivStages+1];
  t4q_pkg::share_t q_r [t4q_pkg::DivStages+1];

  always_comb begin
    p_r[0] = prod;
    d_r[0] = sum;
    r_r[0] = '0;
    q_r[0] = '0;
  end

  for (genvar s = 0; s < t4q_pkg::DivStages; s++) begin : g_st
    logic [17:0] r_nxt;
    logic [18:0] trial;
    always_comb begin
      // Bits 22..7 of prod fold in at step 0 (quotient high bits are zero).
      if (s == 0) r_nxt = 18'(p_r[s] >> 7);
      else r_nxt = {r_r[s][16:0], p_r[s][7-s]};
      trial = {1'b0, r_nxt} - {2'b0, d_r[s]};
    end
    always_ff @(posedge clk) begin
      p_r[s+1] <= p_r[s];
      d_r[s+1] <= d_r[s];
      if (!trial[18]) begin
        r_r[s+1] <= trial[17:0];
        q_r[s+1] <= {q_r[s][6:0], 1'b1};
      end else begin
        r_r[s+1] <= r_nxt;
        q_r[s+1] <= {q_r[s][6:0], 1'b0};
      end
    end
  end

  assign quo_r = q_r[t4q_pkg::DivStages];
  assign rem_r = r_r[t4q_pkg::DivStages][16:0];
endmodule
`default_nettype wire

// ===== sv/t4q_merge.sv =====
// Merge stage: hands leftover units to the largest remainders, registers result.
`default_nettype none
module t4q_merge (
  input  logic clk,
  input  logic rst_n,
  input  t4q_pkg::ctx_t ctx,
  input  t4q_pkg::share_t [t4q_pkg::MaxKeep-1:0] quo,
  input  t4q_pkg::sum_t [t4q_pkg::MaxKeep-1:0] rem,
  output logic out_strobe,
  output t4q_pkg::idx_t [t4q_pkg::MaxKeep-1:0] layer_r,
  output t4q_pkg::share_t [t4q_pkg::MaxKeep-1:0] share_r,
  output logic [2:0] cnt_r
);
  logic [9:0] total;
  logic [2:0] left;
  logic [2:0] pos [t4q_pkg::MaxKeep];
  t4q_pkg::share_t [t4q_pkg::MaxKeep-1:0] share_nxt;
  t4q_pkg::idx_t [t4q_pkg::MaxKeep-1:0] layer_nxt;
  logic strobe_r;

  always_comb begin
    total = '0;
    for (int k = 0; k < t4q_pkg::MaxKeep; k++)
      if (ctx.on[k]) total = total + 10'(quo[k]);
    // At most cnt-1 units remain.
    left = 3'(10'(t4q_pkg::FullScale) - total);
    for (int k = 0; k < t4q_pkg::MaxKeep; k++) begin
      pos[k] = '0;
      for (int j = 0; j < t4q_pkg::MaxKeep; j++)
        if (j != k && ctx.on[j] &&
            ((rem[j] > rem[k]) || ((rem[j] == rem[k]) && (j < k))))
          pos[k] = pos[k] + 3'd1;
      share_nxt[k] = '0;
      layer_nxt[k] = '0;
      if (ctx.on[k]) begin
        share_nxt[k] = quo[k] + ((pos[k] < left) ? 8'd1 : 8'd0);
        layer_nxt[k] = ctx.idx[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= ctx.valid;
    end
    share_r <= share_nxt;
    layer_r <= layer_nxt;
    cnt_r <= ctx.cnt;
  end
  assign out_strobe = strobe_r;
endmodule
`default_nettype wire

// ===== dv/tb_top4_weight_quantizer.sv =====
// Testbench for the top-4 weight quantizer: directed table plus random weight sets.
`timescale 1ns / 100ps
`default_nettype none
module tb_top4_weight_quantizer;
  import t4q_pkg::*;

  localparam int NumDirected = 14;
  localparam int NumRandom = 1700;
  localparam int DrainCycles = 30;
  localparam int StallLimit = 2000;

  typedef struct {
    logic [2:0] layer [MaxKeep];
    logic [7:0] share [MaxKeep];
    logic [2:0] kept;
  } blend_t;

  // One directed row: weights, plus an optional hand-typed expectation.
  typedef struct {
    logic signed [15:0] w [NumIn];
    bit fixed;
    blend_t res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] wt [NumIn];
  logic out_strobe;
  logic [2:0] out_layer_0, out_layer_1, out_layer_2, out_layer_3;
  logic [7:0] out_share_0, out_share_1, out_share_2, out_share_3;
  logic [2:0] out_kept_count;

  blend_t pending_blends[$];
  int errors = 0;
  int idle_cycles = 0;
  bit accepted_now;
  row_t rows [NumDirected];

  always #5 clk = ~clk;

  initial begin
    for (int i = 0; i < NumIn; i++) wt[i] = '0;
  end

  top4_weight_quantizer u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_weight_0(wt[0]), .in_weight_1(wt[1]), .in_weight_2(wt[2]),
    .in_weight_3(wt[3]), .in_weight_4(wt[4]), .in_weight_5(wt[5]),
    .in_weight_6(wt[6]), .in_weight_7(wt[7]),
    .out_strobe(out_strobe),
    .out_layer_0(out_layer_0), .out_layer_1(out_layer_1),
    .out_layer_2(out_layer_2), .out_layer_3(out_layer_3),
    .out_share_0(out_share_0), .out_share_1(out_share_1),
    .out_share_2(out_share_2), .out_share_3(out_share_3),
    .out_kept_count(out_kept_count)
  );

  // Predictor: rank, keep four strongest positive, largest-remainder shares.
  function automatic blend_t quantize_blend(input logic signed [15:0] w [NumIn]);
    blend_t r;
    bit used [NumIn];
    bit taken [MaxKeep];
    int unsigned kw [MaxKeep];
    int unsigned q [MaxKeep];
    int unsigned rm [MaxKeep];
    int unsigned sum, total, left, p;
    int n, best;
    n = 0; sum = 0; total = 0;
    for (int i = 0; i < NumIn; i++) used[i] = 0;
    for (int k = 0; k < MaxKeep; k++) begin
      r.layer[k] = '0; r.share[k] = '0; kw[k] = 0; q[k] = 0; rm[k] = 0; taken[k] = 0;
    end
    while (n < MaxKeep) begin
      best = -1;
      for (int i = 0; i < NumBiomes; i++)
        if (!used[i] && (best < 0 || w[i] > w[best])) best = i;
      if (best < 0 || w[best] <= 0) break;
      used[best] = 1;
      r.layer[n] = best[2:0];
      kw[n] = w[best];
      sum += kw[n];
      n++;
    end
    if (n > 0) begin
      for (int k = 0; k < n; k++) begin
        p = kw[k] * FullScale;
        q[k] = p / sum;
        rm[k] = p % sum;
        total += q[k];
      end
      left = (total < FullScale) ? FullScale - total : 0;
      while (left > 0) begin
        best = -1;
        for (int k = 0; k < n; k++)
          if (!taken[k] && (best < 0 || rm[k] > rm[best])) best = k;
        if (best < 0) break;
        q[best]++; taken[best] = 1; left--;
      end
      for (int k = 0; k < n; k++) r.share[k] = (q[k] > 255) ? 8'd255 : q[k][7:0];
    end
    r.kept = n[2:0];
    return r;
  endfunction

  // start stays high across back-to-back items; dropped only for a gap.
  task automatic send_weights(input logic signed [15:0] w [NumIn], input bit fixed,
                              input blend_t res);
    int gap;
    blend_t exp_blend;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    for (int i = 0; i < NumIn; i++) wt[i] <= w[i];
    start <= 1'b1;
    do @(posedge clk); while (busy);
    exp_blend = fixed ? res : quantize_blend(w);
    pending_blends = {pending_blends, exp_blend};
  endtask

  // Result checker: compare every strobed result against the oldest expectation.
  always @(posedge clk) begin
    blend_t e;
    if (rst_n && out_strobe) begin
      if (pending_blends.size() == 0) begin
        $error("unexpected result");
        errors++;
      end else begin
        e = pending_blends.pop_front();
        if (out_layer_0 !== e.layer[0]) begin
          $error("layer_0 exp %0d got %0d", e.layer[0], out_layer_0); errors++; end
        if (out_layer_1 !== e.layer[1]) begin
          $error("layer_1 exp %0d got %0d", e.layer[1], out_layer_1); errors++; end
        if (out_layer_2 !== e.layer[2]) begin
          $error("layer_2 exp %0d got %0d", e.layer[2], out_layer_2); errors++; end
        if (out_layer_3 !== e.layer[3]) begin
          $error("layer_3 exp %0d got %0d", e.layer[3], out_layer_3); errors++; end
        if (out_share_0 !== e.share[0]) begin
          $error("share_0 exp %0d got %0d", e.share[0], out_share_0); errors++; end
        if (out_share_1 !== e.share[1]) begin
          $error("share_1 exp %0d got %0d", e.share[1], out_share_1); errors++; end
        if (out_share_2 !== e.share[2]) begin
          $error("share_2 exp %0d got %0d", e.share[2], out_share_2); errors++; end
        if (out_share_3 !== e.share[3]) begin
          $error("share_3 exp %0d got %0d", e.share[3], out_share_3); errors++; end
        if (out_kept_count !== e.kept) begin
          $error("kept_count exp %0d got %0d", e.kept, out_kept_count); errors++; end
      end
    end
  end

  // Watchdog: counts cycles with neither an accepted input nor a result.
  always @(posedge clk) begin
    accepted_now = (start && !busy) || out_strobe;
    if (!rst_n || accepted_now) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("FAIL top4_weight_quantizer");
      $finish;
    end
  end

  // Fill one directed row; fixed rows carry a hand-typed expectation.
  function automatic row_t make_row(input int a, b, c, d, e, f, g, h);
    row_t r;
    r.w[0] = 16'(a); r.w[1] = 16'(b); r.w[2] = 16'(c); r.w[3] = 16'(d);
    r.w[4] = 16'(e); r.w[5] = 16'(f); r.w[6] = 16'(g); r.w[7] = 16'(h);
    r.fixed = 0;
    for (int k = 0; k < MaxKeep; k++) begin r.res.layer[k] = 0; r.res.share[k] = 0; end
    r.res.kept = 0;
    return r;
  endfunction

  initial begin
    logic signed [15:0] w [NumIn];
    blend_t none;
    int mode;
    none = quantize_blend('{default: 16'sd0});

    // Directed table. Rows marked fixed are read straight off the spec.
    rows[0] = make_row(0, 0, 0, 0, 0, 0, 0, 0); rows[0].fixed = 1;           // nothing positive
    rows[1] = make_row(-32768, -1, -32768, -5, 0, -32768, -1, 0); rows[1].fixed = 1;
    rows[2] = make_row(0, 0, 0, 32767, 0, 0, 0, 0); rows[2].fixed = 1;       // single keeper
    rows[2].res.layer[0] = 3; rows[2].res.share[0] = 255; rows[2].res.kept = 1;
    rows[3] = make_row(0, 0, 0, 0, 0, 0, 0, 1); rows[3].fixed = 1;           // smallest weight
    rows[3].res.layer[0] = 7; rows[3].res.share[0] = 255; rows[3].res.kept = 1;
    rows[4] = make_row(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767); // all max, ties
    rows[5] = make_row(1, 1, 1, 1, 1, 1, 1, 1);         // ties, three-way remainder split
    rows[6] = make_row(100, 100, 100, 0, 0, 0, 0, 0);   // equal thirds
    rows[7] = make_row(-1, 5, -32768, 7, 32767, -2, 3, 9);
    rows[8] = make_row(1, 2, 3, 4, 5, 6, 7, 8);          // highest index wins
    rows[9] = make_row(8, 7, 6, 5, 4, 3, 2, 1);
    rows[10] = make_row(32767, 1, 1, 1, 0, 0, 0, 0);     // tiny shares
    rows[11] = make_row(0, 2, 0, 1, 0, 0, 0, 0);         // two keepers
    rows[12] = make_row(21845, 21845, 21846, -32768, 0, 0, 0, 0);
    rows[13] = make_row(-21846, 10923, -1, 10922, 32766, 16384, 8192, 4096);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[r]) send_weights(rows[r].w, rows[r].fixed, rows[r].fixed ? rows[r].res : none);

    for (int n = 0; n < NumRandom; n++) begin
      // Pause until the pipeline drains, once midway.
      if (n == NumRandom / 2) begin
        start <= 1'b0;
        wait (pending_blends.size() == 0);
      end
      mode = $urandom_range(0, 5);
      for (int i = 0; i < NumIn; i++) begin
        case (mode)
          0: w[i] = 16'($urandom());                             // full range
          1: w[i] = 16'($urandom_range(0, 32767));               // all non-negative
          2: w[i] = 16'($urandom_range(0, 3) ? $urandom_range(0, 8) : -$urandom_range(0, 8));
          3: w[i] = 16'(($urandom_range(0, 4) == 0) ? $urandom_range(1, 32767)
                                                     : -$urandom_range(0, 100));
          4: w[i] = ($urandom_range(0, 1)) ? 16'sd32767 : 16'sh8000;
          default: w[i] = 16'($urandom_range(1, 5) * 1000 + $urandom_range(0, 2));
        endcase
      end
      send_weights(w, 1'b0, none);
    end
    start <= 1'b0;

    wait (pending_blends.size() == 0);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0) begin
      $display("PASS top4_weight_quantizer");
    end else begin
      $display("FAIL top4_weight_quantizer");
    end
    $finish;
  end
endmodule
`default_nettype wire
